>>> hw/rtl/ftsr_pkg.sv
// shared types, constants and helpers of the fan tach speed regulator
package ftsr_pkg;

  // field widths
  localparam int DUTY_W   = 16;
  localparam int SPEED_W  = 13;
  localparam int TIMER_W  = 16;
  localparam int PULSE_W  = 8;
  localparam int DEB_W    = 3;
  localparam int WAIT_W   = 6;
  localparam int STALL_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W   = 7;
  localparam int DIFF_W   = 17;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // period to speed divider
  localparam int DIV_W   = 20;
  localparam int DIV_CNT_W = 5;
  localparam int REM_W   = TIMER_W + 1;
  localparam logic [DIV_W-1:0] SPEED_DIVIDEND = 20'd960000;

  // constants of the regulation law
  localparam logic [TIMER_W-1:0] TIMER_MAX     = 16'hffff;
  localparam logic [TIMER_W-1:0] PERIOD_MIN    = 16'd228;
  localparam logic [SPEED_W-1:0] SPEED_SAT     = 13'd8191;
  localparam logic [SPEED_W-1:0] SPEED_MEAS_MAX = 13'd4193;
  localparam logic [SPEED_W-1:0] SPEED_STALL   = 13'd50;
  localparam logic [WAIT_W-1:0]  ADJUST_TICKS  = 6'd50;
  localparam logic [STALL_W-1:0] STALL_SAT     = 8'd255;
  localparam logic [STALL_W-1:0] STALL_FAULT   = 8'd100;
  localparam logic [DIFF_W-1:0]  SPEED_BAND    = 17'd5;
  localparam logic [DIFF_W-1:0]  DUTY_SAT      = 17'h0ffff;
  localparam logic signed [DEB_W-1:0] DEB_HIGH = 3'sd2;
  localparam logic signed [DEB_W-1:0] DEB_LOW  = -3'sd2;

  // configuration reset values
  localparam logic [DUTY_W-1:0]  DUTY_INIT_RST  = 16'd300;
  localparam logic [DUTY_W-1:0]  DUTY_FLOOR_RST = 16'd100;
  localparam logic [DUTY_W-1:0]  DUTY_CEIL_RST  = 16'd1000;
  localparam logic [PULSE_W-1:0] PULSES_RST     = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY_INIT  = 2'd0,
    CFG_DUTY_FLOOR = 2'd1,
    CFG_DUTY_CEIL  = 2'd2,
    CFG_PULSES     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_PROCESS = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } core_state_e;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_init;
    logic [DUTY_W-1:0]  duty_floor;
    logic [DUTY_W-1:0]  duty_ceil;
    logic [PULSE_W-1:0] pulses_per_measure;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic              tach_level;
    logic [DUTY_W-1:0] target_speed;
    logic              pwm_enable;
    logic              tick_10ms;
    logic              tick_100ms;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [SPEED_W-1:0] current_speed;
    logic               fan_fault;
  } result_t;

  typedef struct packed {
    logic [TIMER_W-1:0] period_timer;
    logic [PULSE_W-1:0] pulse_counter;
    logic [TIMER_W-1:0] latched_period;
    logic [DEB_W-1:0]   debounce_count;
    logic               tach_high_seen;
    logic [SPEED_W-1:0] speed_value;
    logic [DUTY_W-1:0]  duty_value;
    logic [WAIT_W-1:0]  adjust_wait;
    logic [STALL_W-1:0] stall_count;
    logic               fault_flag;
  } regs_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_status_t;

  // duty step for a given speed error
  function automatic logic [STEP_W-1:0] step_size(input logic [DIFF_W-1:0] diff);
    logic [STEP_W-1:0] st;
    if (diff <= 17'd50) st = 7'd1;
    else if (diff <= 17'd100) st = 7'd2;
    else if (diff <= 17'd200) st = 7'd8;
    else if (diff <= 17'd300) st = 7'd32;
    else st = 7'd64;
    return st;
  endfunction

endpackage

>>> hw/rtl/ftsr_ifs.sv
// command and result channel interfaces

interface ftsr_cmd_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        tach_level;
  logic [15:0] target_speed;
  logic        pwm_enable;
  logic        tick_10ms;
  logic        tick_100ms;

  modport source (
    output valid, operation, tach_level, target_speed, pwm_enable, tick_10ms, tick_100ms,
    input  ready
  );
  modport sink (
    input  valid, operation, tach_level, target_speed, pwm_enable, tick_10ms, tick_100ms,
    output ready
  );
endinterface

interface ftsr_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic [12:0] current_speed;
  logic        fan_fault;

  modport source (
    output valid, duty, current_speed, fan_fault,
    input  ready
  );
  modport sink (
    input  valid, duty, current_speed, fan_fault,
    output ready
  );
endinterface

>>> hw/rtl/ftsr_front.sv
// front end: accepts command beats, classifies them and queues them for the back end
module ftsr_front (
  input  logic           clk,
  input  logic           rst,
  ftsr_cmd_if.sink       cmd,
  output ftsr_pkg::item_t head,
  output logic           head_valid,
  input  logic           pop
);
  import ftsr_pkg::*;

  item_t              entry [Q_DEPTH];
  item_t              incoming;
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;

  // classify the incoming beat
  always_comb begin
    incoming.op           = cmd.operation ? OP_PROCESS : OP_SAMPLE;
    incoming.tach_level   = cmd.tach_level;
    incoming.target_speed = cmd.target_speed;
    incoming.pwm_enable   = cmd.pwm_enable;
    incoming.tick_10ms    = cmd.tick_10ms;
    incoming.tick_100ms   = cmd.tick_100ms;
  end

  assign cmd.ready  = (count != Q_CNT_W'(Q_DEPTH));
  assign push       = cmd.valid && cmd.ready;
  assign head_valid = (count != '0);
  assign head       = entry[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= Q_CNT_W'(Q_DEPTH)) && !(pop && count == '0))
    else $error("command queue over- or underflow");

endmodule

>>> hw/rtl/ftsr_div.sv
// iterative restoring divider: 960000 / period, one quotient bit per cycle
module ftsr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ftsr_pkg::TIMER_W-1:0]  divisor,
  output ftsr_pkg::div_status_t         status
);
  import ftsr_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [REM_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [TIMER_W-1:0]   dvsr;
  logic [REM_W-1:0]     trial;
  logic                 fits;

  // one shift-subtract step
  assign trial = {rem[REM_W-2:0], quo[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= SPEED_DIVIDEND;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, dvsr}) : trial;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign status.done     = done;
  assign status.quotient = quo;

endmodule

>>> hw/rtl/ftsr_core.sv
// back end: tach measurement, speed, stall fault and duty regulation, result register
module ftsr_core (
  input  logic            clk,
  input  logic            rst,
  input  ftsr_pkg::cfg_t  cfg,
  input  ftsr_pkg::item_t head,
  input  logic            head_valid,
  output logic            pop,
  ftsr_rsp_if.source      rsp
);
  import ftsr_pkg::*;

  core_state_e        state;
  core_state_e        state_next;
  regs_t              regs;
  regs_t              regs_next;
  regs_t              s_regs;
  regs_t              p_regs;
  result_t            out_data;
  logic               rsp_valid;
  logic               out_free;
  logic               out_load;
  logic               div_start;
  div_status_t        div_stat;
  logic [SPEED_W-1:0] div_speed;

  ftsr_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (regs.latched_period),
    .status  (div_stat)
  );

  assign div_speed = (div_stat.quotient > DIV_W'(SPEED_SAT)) ? SPEED_SAT
                                                               : div_stat.quotient[SPEED_W-1:0];
  assign out_free  = !rsp_valid || rsp.ready;

  // sample tick: period timer, debounce, pulse counting
  always_comb begin
    logic signed [DEB_W-1:0] dc;
    logic [PULSE_W-1:0]      pc;
    s_regs = regs;
    pc = '0;
    dc = $signed(regs.debounce_count);
    if (s_regs.period_timer != TIMER_MAX) s_regs.period_timer = s_regs.period_timer + 1'b1;
    if (head.tach_level) begin
      if (dc < 3'sd0) dc = 3'sd0;
      if (dc < DEB_HIGH) dc = dc + 3'sd1;
      else s_regs.tach_high_seen = 1'b1;
    end else begin
      if (dc > 3'sd0) dc = 3'sd0;
      if (dc > DEB_LOW) begin
        dc = dc - 3'sd1;
      end else if (s_regs.tach_high_seen) begin
        s_regs.tach_high_seen = 1'b0;
        pc = s_regs.pulse_counter + 1'b1;
        s_regs.pulse_counter = pc;
        if (pc >= cfg.pulses_per_measure && s_regs.period_timer > PERIOD_MIN) begin
          if (s_regs.latched_period == '0) s_regs.latched_period = s_regs.period_timer;
          s_regs.pulse_counter = '0;
          s_regs.period_timer  = '0;
        end
      end
    end
    s_regs.debounce_count = dc;
  end

  // process step: speed update, stall tracking, duty regulation
  always_comb begin
    logic [DIFF_W-1:0] cur;
    logic [DIFF_W-1:0] tgt;
    logic [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] st;
    logic              run;
    p_regs = regs;
    cur = '0;
    d   = '0;
    st  = '0;
    tgt = {1'b0, head.target_speed};
    run = (head.target_speed != '0) && head.pwm_enable;

    if (p_regs.period_timer == TIMER_MAX) begin
      p_regs.speed_value   = '0;
      p_regs.pulse_counter = '0;
      p_regs.period_timer  = '0;
    end else if (p_regs.latched_period != '0) begin
      p_regs.speed_value    = div_speed;
      p_regs.adjust_wait    = '0;
      p_regs.latched_period = '0;
    end

    // stall counting
    if (head.target_speed != '0 && p_regs.speed_value < SPEED_STALL) begin
      if (head.tick_100ms && p_regs.stall_count != STALL_SAT)
        p_regs.stall_count = p_regs.stall_count + 1'b1;
    end else begin
      p_regs.stall_count = '0;
    end

    if (!head.pwm_enable) begin
      p_regs.latched_period = '0;
      p_regs.speed_value    = '0;
      p_regs.pulse_counter  = '0;
      p_regs.stall_count    = '0;
    end

    if (p_regs.stall_count >= STALL_FAULT) p_regs.fault_flag = 1'b1;

    // tiered duty adjustment
    if (run) begin
      if (p_regs.adjust_wait != '0) begin
        if (head.tick_10ms) p_regs.adjust_wait = p_regs.adjust_wait - 1'b1;
      end else begin
        p_regs.adjust_wait = ADJUST_TICKS;
        cur = {{(DIFF_W - SPEED_W){1'b0}}, p_regs.speed_value};
        d   = {1'b0, p_regs.duty_value};
        if (d == '0) begin
          d = {1'b0, cfg.duty_init};
        end else if (tgt > cur + SPEED_BAND) begin
          d = d + {{(DIFF_W - STEP_W){1'b0}}, step_size(tgt - cur)};
          if (d > DUTY_SAT) d = DUTY_SAT;
        end else if (tgt + SPEED_BAND < cur) begin
          st = {{(DIFF_W - STEP_W){1'b0}}, step_size(cur - tgt)};
          d  = (d > st) ? (d - st) : '0;
        end
        if (d > {1'b0, cfg.duty_ceil}) d = {1'b0, cfg.duty_ceil};
        else if (d < {1'b0, cfg.duty_floor}) d = {1'b0, cfg.duty_floor};
        p_regs.duty_value = d[DUTY_W-1:0];
      end
    end else begin
      p_regs.duty_value  = '0;
      p_regs.adjust_wait = '0;
    end
  end

  // sequencer: next state and controls
  always_comb begin
    state_next = state;
    regs_next  = regs;
    pop        = 1'b0;
    out_load   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head_valid && out_free) begin
          if (head.op == OP_SAMPLE) begin
            regs_next = s_regs;
            pop       = 1'b1;
            out_load  = 1'b1;
          end else if (regs.period_timer != TIMER_MAX && regs.latched_period != '0) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else begin
            regs_next = p_regs;
            pop       = 1'b1;
            out_load  = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          regs_next  = p_regs;
          pop        = 1'b1;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register and regulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      regs  <= '0;
    end else begin
      state <= state_next;
      regs  <= regs_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.duty          <= regs_next.duty_value;
      out_data.current_speed <= regs_next.speed_value;
      out_data.fan_fault     <= regs_next.fault_flag;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.duty          = out_data.duty;
  assign rsp.current_speed = out_data.current_speed;
  assign rsp.fan_fault     = out_data.fan_fault;

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    regs.speed_value <= SPEED_MEAS_MAX)
    else $error("measured speed out of range");

  a_debounce_range: assert property (@(posedge clk) disable iff (rst)
    ($signed(regs.debounce_count) >= DEB_LOW) && ($signed(regs.debounce_count) <= DEB_HIGH))
    else $error("debounce count out of range");

  a_div_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_FINISH) |-> (head_valid && regs.latched_period != '0))
    else $error("divide in flight without a pending period");

  a_finish_after_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> ($past(div_stat.done) || $past(state == ST_FINISH)))
    else $error("finish entered without divider completion");

endmodule

>>> hw/rtl/fan_tach_speed_regulator_top.sv
// top level: configuration registers, command front end and regulator back end
//
// Every accepted command beat yields exactly one result beat carrying duty, speed and
// the stall fault after that command. Sample ticks and process steps that find no new
// period pending pass through the queue entry and the result register, so the block
// sustains one beat per cycle while the result side keeps up. A process step that finds
// a latched period while the period timer is not saturated runs the 20-bit restoring
// divider for 960000 / period, one quotient bit per cycle, before its result is
// registered; the two-entry command queue takes one more beat in the meantime and then
// holds ready low. Configuration writes take effect on the next cycle and should be
// made while no command is in flight.
module fan_tach_speed_regulator_top (
  input  logic                              clk,
  input  logic                              rst,
  ftsr_cmd_if.sink                          cmd,
  ftsr_rsp_if.source                        rsp,
  input  logic                              cfg_we,
  input  logic [ftsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ftsr_pkg::*;

  cfg_t  cfg;
  item_t head;
  logic  head_valid;
  logic  pop;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_init          <= DUTY_INIT_RST;
      cfg.duty_floor         <= DUTY_FLOOR_RST;
      cfg.duty_ceil          <= DUTY_CEIL_RST;
      cfg.pulses_per_measure <= PULSES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_DUTY_INIT:  cfg.duty_init          <= cfg_data;
        CFG_DUTY_FLOOR: cfg.duty_floor         <= cfg_data;
        CFG_DUTY_CEIL:  cfg.duty_ceil          <= cfg_data;
        CFG_PULSES:     cfg.pulses_per_measure <= cfg_data[PULSE_W-1:0];
        default:        ;
      endcase
    end
  end

  ftsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  ftsr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule
